// File: hw/rtl/rtph_pkg.sv
// Package for the RTP header parser: record type, status codes and
// fixed protocol constants. No dependencies.
`timescale 1ns / 1ps
package rtph_pkg;

	// Summary status codes
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT       = 3'd1,
		ST_VERSION     = 3'd2,
		ST_CSRC_TRUNC  = 3'd3,
		ST_ZERO_PAD    = 3'd4,
		ST_EXT_HDR     = 3'd5,
		ST_EXT_OVERRUN = 3'd6,
		ST_PAD_OVERRUN = 3'd7
	} sum_status_t;

	// Record kinds
	localparam logic KIND_ELEMENT = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Element status
	localparam logic [2:0] EL_NEW = 3'd0;
	localparam logic [2:0] EL_DUP = 3'd1;

	localparam logic [15:0] PROFILE_ONE_BYTE = 16'hBEDE;
	localparam logic [11:0] PROFILE_TWO_BYTE = 12'h100;
	localparam logic [1:0]  RTP_VERSION      = 2'd2;
	localparam logic [3:0]  ID_RESERVED      = 4'hF;

	localparam int unsigned FIX_HDR_BYTES = 12;

	// One output transaction
	typedef struct packed {
		logic        kind;
		logic [2:0]  status;
		logic        marker;
		logic [6:0]  pt_code;
		logic [15:0] seq_num;
		logic [31:0] timestamp;
		logic [31:0] ssrc;
		logic [15:0] offset;
		logic [15:0] payload_size;
		logic [7:0]  padding_size;
		logic [7:0]  element_id;
		logic [7:0]  element_length;
	} rec_t;

endpackage

// File: hw/rtl/rtp_header_parser.sv
// RTP header parser top level: byte-wide packet decoder with extension walk
// and a four-entry result queue. Depends on rtph_pkg.
`timescale 1ns / 1ps
// One byte per clock is accepted while the result queue holds at most two
// records. A byte goes into an input register, is decoded there and its
// records (at most an extension element record and, on the last byte, the
// packet summary) are pushed into a four-entry result queue, whose head
// drives the outputs from its registers. The sustained rate is one byte per
// cycle as long as results are taken, since only the last byte of a packet
// can add a second record. Element records are speculative: the summary
// status tells whether the packet and its elements are good. Duplicate
// tracking uses ID_SPACE flags that are cleared at once at the end of each
// packet; the byte count saturates at 2^COUNT_BITS-1.
module rtp_header_parser #(
	parameter int COUNT_BITS = 16,
	parameter int ID_SPACE   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        record_kind,
	output logic [2:0]  status,
	output logic        marker,
	output logic [6:0]  pt_code,
	output logic [15:0] seq_num,
	output logic [31:0] timestamp,
	output logic [31:0] ssrc,
	output logic [15:0] offset,
	output logic [15:0] payload_size,
	output logic [7:0]  padding_size,
	output logic [7:0]  element_id,
	output logic [7:0]  element_length
);
	import rtph_pkg::*;

	localparam int SW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
	localparam logic [COUNT_BITS-1:0] MAX_COUNT = {COUNT_BITS{1'b1}};

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Packet state
	logic [COUNT_BITS-1:0] pos_q, pos_nx;
	logic [7:0]            flags_q, flags_nx;
	logic [55:0]           ff0_q, ff0_nx;
	logic [31:0]           ff1_q, ff1_nx;
	logic [3:0]            csrc_q, csrc_nx;
	logic [15:0]           prof_q, prof_nx;
	logic [17:0]           cap_q, cap_nx;
	logic [17:0]           walk_q, walk_nx;
	logic [7:0]            left_q, left_nx;
	logic                  stop_q, stop_nx;
	logic [7:0]            pend_id_q, pend_id_nx;
	logic                  pend_q, pend_nx;
	logic [ID_SPACE-1:0]   seen_q, seen_nx;

	// Result queue
	rec_t       rec_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;

	logic do_proc, pop;
	rec_t elem_rec, sum_rec;
	logic elem_valid;

	// id to flag slot, worked out at elaboration
	logic [SW-1:0] slot_lut [256];
	for (genvar j = 0; j < 256; j++) begin : g_slot
		assign slot_lut[j] = SW'(j % ID_SPACE);
	end

	assign pop      = out_valid && out_ready;
	assign do_proc  = valid_s1 && (cnt_q <= 3'd2);
	assign in_ready = !valid_s1 || do_proc;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Decode of one byte: next state and records
	logic [COUNT_BITS-1:0] p, n;
	logic [7:0]  base, eo, b;
	logic        has_ext, one;
	logic [18:0] w19, cap19, n19, po, lim;
	logic [1:0]  k;
	logic [4:0]  len1;
	logic [2:0]  st;
	logic [7:0]  pad;
	logic [7:0]  e_id, e_len;
	logic [15:0] e_off;
	logic [SW-1:0] slot;

	always_comb begin
		b       = byte_s1;
		p       = pos_q;
		n       = (pos_q == MAX_COUNT) ? pos_q : pos_q + 1'b1;
		base    = 8'(FIX_HDR_BYTES) + {2'b00, csrc_q, 2'b00};
		eo      = base + 8'd4;
		has_ext = flags_q[4];
		one     = (prof_q == PROFILE_ONE_BYTE);
		w19     = {1'b0, walk_q};
		cap19   = {1'b0, cap_q};
		k       = 2'(p[1:0] - base[1:0]);
		len1    = 5'd1 + {1'b0, b[3:0]};

		pos_nx     = n;
		flags_nx   = flags_q;
		ff0_nx     = ff0_q;
		ff1_nx     = ff1_q;
		csrc_nx    = csrc_q;
		prof_nx    = prof_q;
		cap_nx     = cap_q;
		walk_nx    = walk_q;
		left_nx    = left_q;
		stop_nx    = stop_q;
		pend_id_nx = pend_id_q;
		pend_nx    = pend_q;
		seen_nx    = seen_q;
		elem_valid = 1'b0;
		e_id       = '0;
		e_len      = '0;
		e_off      = 16'(eo) + walk_q[15:0] + 16'd1;

		if (p == '0) begin
			flags_nx = b;
			csrc_nx  = b[3:0];
		end else if (p <= COUNT_BITS'(7)) begin
			ff0_nx = {ff0_q[47:0], b};
		end else if (p <= COUNT_BITS'(11)) begin
			ff1_nx = {ff1_q[23:0], b};
		end else if (has_ext && p >= COUNT_BITS'(base) && p < COUNT_BITS'(eo)) begin
			// extension header: profile, then length in words
			case (k)
				2'd0, 2'd1: prof_nx = {prof_q[7:0], b};
				2'd2:       cap_nx = {2'b00, b, 8'h00};
				default: begin
					cap_nx  = {cap_q[15:8], b, 2'b00};
					stop_nx = !(one || prof_q[15:4] == PROFILE_TWO_BYTE);
					walk_nx = '0;
					left_nx = '0;
					pend_nx = 1'b0;
				end
			endcase
		end else if (has_ext && p >= COUNT_BITS'(eo)) begin
			// element walk
			if (!stop_q) begin
				if (left_q != '0) begin
					left_nx = left_q - 8'd1;
				end else if (pend_q) begin
					pend_nx = 1'b0;
					if (w19 + 19'd1 + 19'(b) > cap19) begin
						stop_nx = 1'b1;
					end else begin
						elem_valid = 1'b1;
						e_id       = pend_id_q;
						e_len      = b;
						left_nx    = b;
					end
				end else if (w19 + (one ? 19'd1 : 19'd2) >= cap19) begin
					stop_nx = 1'b1;
				end else if (b == 8'h00) begin
					// padding between elements
				end else if (one) begin
					if (b[7:4] == ID_RESERVED || b[7:4] == 4'h0 ||
					    w19 + 19'd1 + 19'(len1) > cap19) begin
						stop_nx = 1'b1;
					end else begin
						elem_valid = 1'b1;
						e_id       = {4'h0, b[7:4]};
						e_len      = {3'b000, len1};
						left_nx    = {3'b000, len1};
					end
				end else begin
					pend_id_nx = b;
					pend_nx    = 1'b1;
				end
			end
			if (walk_q != 18'h3ffff) begin
				walk_nx = walk_q + 18'd1;
			end
		end

		// duplicate tracking
		slot = slot_lut[e_id];
		elem_rec                = '0;
		elem_rec.kind           = KIND_ELEMENT;
		elem_rec.status         = seen_q[slot] ? EL_DUP : EL_NEW;
		elem_rec.marker         = ff0_nx[55];
		elem_rec.pt_code        = ff0_nx[54:48];
		elem_rec.seq_num        = ff0_nx[47:32];
		elem_rec.timestamp      = ff0_nx[31:0];
		elem_rec.ssrc           = ff1_nx;
		elem_rec.offset         = e_off;
		elem_rec.element_id     = e_id;
		elem_rec.element_length = e_len;
		if (elem_valid) begin
			seen_nx[slot] = (e_len != 8'd0);
		end

		// packet summary
		n19 = 19'(n);
		st  = ST_OK;
		pad = 8'd0;
		po  = 19'(base);
		lim = 19'(eo) + {1'b0, cap_nx};
		if (n19 < 19'(FIX_HDR_BYTES)) begin
			st = ST_SHORT;
		end else if (flags_nx[7:6] != RTP_VERSION) begin
			st = ST_VERSION;
		end else if (n19 < 19'(base)) begin
			st = ST_CSRC_TRUNC;
		end else begin
			if (flags_nx[5]) begin
				pad = b;
				if (b == 8'd0) st = ST_ZERO_PAD;
			end
			if (st == ST_OK && has_ext) begin
				if (n19 < 19'(eo)) st = ST_EXT_HDR;
				else if (n19 < lim) st = ST_EXT_OVERRUN;
				else po = lim;
			end
			if (st == ST_OK && po + 19'(pad) > n19) st = ST_PAD_OVERRUN;
		end
		sum_rec           = '0;
		sum_rec.kind      = KIND_SUMMARY;
		sum_rec.status    = st;
		sum_rec.marker    = ff0_nx[55];
		sum_rec.pt_code   = ff0_nx[54:48];
		sum_rec.seq_num   = ff0_nx[47:32];
		sum_rec.timestamp = ff0_nx[31:0];
		sum_rec.ssrc      = ff1_nx;
		if (st == ST_OK) begin
			sum_rec.offset       = po[15:0];
			sum_rec.payload_size = 16'(n19 - po - 19'(pad));
			sum_rec.padding_size = pad;
		end
	end

	// Packet state registers, cleared after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			flags_q   <= '0;
			ff0_q     <= '0;
			ff1_q     <= '0;
			csrc_q    <= '0;
			prof_q    <= '0;
			cap_q     <= '0;
			walk_q    <= '0;
			left_q    <= '0;
			stop_q    <= 1'b0;
			pend_id_q <= '0;
			pend_q    <= 1'b0;
			seen_q    <= '0;
		end else if (do_proc) begin
			if (last_s1) begin
				pos_q     <= '0;
				flags_q   <= '0;
				ff0_q     <= '0;
				ff1_q     <= '0;
				csrc_q    <= '0;
				prof_q    <= '0;
				cap_q     <= '0;
				walk_q    <= '0;
				left_q    <= '0;
				stop_q    <= 1'b0;
				pend_id_q <= '0;
				pend_q    <= 1'b0;
				seen_q    <= '0;
			end else begin
				pos_q     <= pos_nx;
				flags_q   <= flags_nx;
				ff0_q     <= ff0_nx;
				ff1_q     <= ff1_nx;
				csrc_q    <= csrc_nx;
				prof_q    <= prof_nx;
				cap_q     <= cap_nx;
				walk_q    <= walk_nx;
				left_q    <= left_nx;
				stop_q    <= stop_nx;
				pend_id_q <= pend_id_nx;
				pend_q    <= pend_nx;
				seen_q    <= seen_nx;
			end
		end
	end

	// Result queue
	logic [1:0] n_push;
	assign n_push = do_proc ? (2'(elem_valid) + 2'(last_s1)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(n_push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			rec_q[wr_q] <= elem_valid ? elem_rec : sum_rec;
		end
		if (n_push == 2'd2) begin
			rec_q[wr_q + 2'd1] <= sum_rec;
		end
	end

	assign out_valid      = (cnt_q != 3'd0);
	assign record_kind    = rec_q[rd_q].kind;
	assign status         = rec_q[rd_q].status;
	assign marker         = rec_q[rd_q].marker;
	assign pt_code        = rec_q[rd_q].pt_code;
	assign seq_num        = rec_q[rd_q].seq_num;
	assign timestamp      = rec_q[rd_q].timestamp;
	assign ssrc           = rec_q[rd_q].ssrc;
	assign offset         = rec_q[rd_q].offset;
	assign payload_size   = rec_q[rd_q].payload_size;
	assign padding_size   = rec_q[rd_q].padding_size;
	assign element_id     = rec_q[rd_q].element_id;
	assign element_length = rec_q[rd_q].element_length;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("result queue overflow");

	a_pkt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		do_proc && last_s1 |=> pos_q == '0 && seen_q == '0)
		else $error("packet state not cleared after last byte");

	a_pend_form: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> prof_q != PROFILE_ONE_BYTE)
		else $error("pending id in one-byte form");

	a_left_walk: assert property (@(posedge clk) disable iff (!arst_n)
		left_q != 8'd0 |-> !stop_q && !pend_q)
		else $error("element data count while walk stopped or id pending");

endmodule
